// File: rtl/y2b_pkg.sv
package y2b_pkg;

    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 12;
    localparam int PPR_W       = 11;
    localparam int RPF_W       = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_PAIRS_PER_ROW  = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS_PER_FRAME = CFG_INDEX_W'(1);

    // BT.601 limited-range coefficients, 8 fractional bits
    localparam logic signed [19:0] K_LUMA  = 20'sd298;
    localparam logic signed [19:0] K_R_CR  = 20'sd409;
    localparam logic signed [19:0] K_G_CB  = -20'sd100;
    localparam logic signed [19:0] K_G_CR  = -20'sd208;
    localparam logic signed [19:0] K_B_CB  = 20'sd516;
    localparam logic signed [19:0] K_ROUND = 20'sd128;
    localparam logic signed [19:0] K_BLACK = 20'sd16;
    localparam logic signed [19:0] K_MID   = 20'sd128;
    localparam logic signed [19:0] K_MAX8  = 20'sd255;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        logic [7:0] chroma_blue;
        logic [7:0] chroma_red;
        logic       row_end;
        logic       frame_end;
    } t_pair;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_bgr;

    function automatic logic [7:0] clamp8(input logic signed [19:0] v);
        logic [7:0] res;
        if (v < 20'sd0) begin
            res = 8'h00;
        end else if (v > K_MAX8) begin
            res = 8'hFF;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    // every term is rounded and floor-shifted separately
    function automatic t_bgr convert_pixel(input logic [7:0] y, input logic [7:0] cb,
                                           input logic [7:0] cr);
        logic signed [19:0] ys;
        logic signed [19:0] d;
        logic signed [19:0] e;
        logic signed [19:0] c;
        logic signed [19:0] r;
        logic signed [19:0] g;
        logic signed [19:0] b;
        t_bgr               px;
        ys = $signed({12'b0, y});
        d  = $signed({12'b0, cb}) - K_MID;
        e  = $signed({12'b0, cr}) - K_MID;
        c  = ((ys - K_BLACK) * K_LUMA + K_ROUND) >>> 8;
        r  = c + ((K_R_CR * e + K_ROUND) >>> 8);
        g  = c + ((K_G_CB * d + K_ROUND) >>> 8) + ((K_G_CR * e + K_ROUND) >>> 8);
        b  = c + ((K_B_CB * d + K_ROUND) >>> 8);
        px.blue  = clamp8(b);
        px.green = clamp8(g);
        px.red   = clamp8(r);
        return px;
    endfunction

endpackage

// File: rtl/y2b_line_ctrl.sv
module y2b_line_ctrl #(
    parameter int MAX_PAIRS = 1024,
    parameter int MAX_ROWS  = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [y2b_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [y2b_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_luma_first,
    input  logic [7:0]                      i_luma_second,
    input  logic [7:0]                      i_chroma_blue,
    input  logic [7:0]                      i_chroma_red,
    output logic                            o_pair_valid,
    input  logic                            i_pair_ready,
    output y2b_pkg::t_pair                  o_pair
);
    import y2b_pkg::*;

    localparam int COL_W = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [COL_W-1:0] r_col, n_col, r_col_last;
    logic [ROW_W-1:0] r_row, n_row, r_row_last;
    logic             r_valid;
    logic             w_accept;
    logic             w_row_last;
    logic             w_frame_last;

    logic [31:0]      w_ppr, w_ppr_lim;
    logic [31:0]      w_rpf, w_rpf_lim;

    logic [15:0]      r_chroma_line [MAX_PAIRS];
    logic [15:0]      r_line_q;
    logic [7:0]       r_y0, r_y1, r_cb, r_cr;
    logic             r_odd, r_row_end, r_frame_end;

    // out-of-range register values: zero acts as one, above max acts as max
    always_comb begin
        w_ppr     = 32'(i_cfg_data[PPR_W-1:0]);
        w_rpf     = 32'(i_cfg_data[RPF_W-1:0]);
        w_ppr_lim = (w_ppr == 32'd0) ? 32'd1 :
                    (w_ppr > 32'(MAX_PAIRS)) ? 32'(MAX_PAIRS) : w_ppr;
        w_rpf_lim = (w_rpf == 32'd0) ? 32'd1 :
                    (w_rpf > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : w_rpf;
    end

    assign o_ready      = !r_valid || i_pair_ready;
    assign w_accept     = i_valid && o_ready;
    assign w_row_last   = (r_col >= r_col_last);
    assign w_frame_last = w_row_last && (r_row >= r_row_last);

    always_comb begin
        n_col = r_col + COL_W'(1);
        n_row = r_row;
        if (w_row_last) begin
            n_col = '0;
            n_row = w_frame_last ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_col_last <= '0;
            r_row_last <= '0;
        end else begin
            if (i_cfg_valid && i_cfg_index == REG_PAIRS_PER_ROW) begin
                r_col_last <= COL_W'(w_ppr_lim - 32'd1);
            end
            if (i_cfg_valid && i_cfg_index == REG_ROWS_PER_FRAME) begin
                r_row_last <= ROW_W'(w_rpf_lim - 32'd1);
            end
            if (w_accept) begin
                r_valid <= 1'b1;
                r_col   <= n_col;
                r_row   <= n_row;
            end else if (i_pair_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // even rows write the chroma line, odd rows read it back
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            if (!r_row[0]) begin
                r_chroma_line[r_col] <= {i_chroma_red, i_chroma_blue};
            end else begin
                r_line_q <= r_chroma_line[r_col];
            end
            r_y0        <= i_luma_first;
            r_y1        <= i_luma_second;
            r_cb        <= i_chroma_blue;
            r_cr        <= i_chroma_red;
            r_odd       <= r_row[0];
            r_row_end   <= w_row_last;
            r_frame_end <= w_frame_last;
        end
    end

    assign o_pair_valid        = r_valid;
    assign o_pair.luma_first   = r_y0;
    assign o_pair.luma_second  = r_y1;
    assign o_pair.chroma_blue  = r_odd ? r_line_q[7:0]  : r_cb;
    assign o_pair.chroma_red   = r_odd ? r_line_q[15:8] : r_cr;
    assign o_pair.row_end      = r_row_end;
    assign o_pair.frame_end    = r_frame_end;

endmodule

// File: rtl/y2b_convert.sv
module y2b_convert (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_pair_valid,
    output logic           o_pair_ready,
    input  y2b_pkg::t_pair i_pair,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [7:0]     o_blue_first,
    output logic [7:0]     o_green_first,
    output logic [7:0]     o_red_first,
    output logic [7:0]     o_blue_second,
    output logic [7:0]     o_green_second,
    output logic [7:0]     o_red_second,
    output logic           o_row_end,
    output logic           o_frame_end
);
    import y2b_pkg::*;

    logic r_valid;
    logic w_load;
    t_bgr w_px0, w_px1;
    t_bgr r_px0, r_px1;
    logic r_row_end, r_frame_end;

    assign o_pair_ready = !r_valid || i_ready;
    assign w_load       = i_pair_valid && o_pair_ready;

    assign w_px0 = convert_pixel(i_pair.luma_first,  i_pair.chroma_blue, i_pair.chroma_red);
    assign w_px1 = convert_pixel(i_pair.luma_second, i_pair.chroma_blue, i_pair.chroma_red);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_px0       <= w_px0;
            r_px1       <= w_px1;
            r_row_end   <= i_pair.row_end;
            r_frame_end <= i_pair.frame_end;
        end
    end

    assign o_valid        = r_valid;
    assign o_blue_first   = r_px0.blue;
    assign o_green_first  = r_px0.green;
    assign o_red_first    = r_px0.red;
    assign o_blue_second  = r_px1.blue;
    assign o_green_second = r_px1.green;
    assign o_red_second   = r_px1.red;
    assign o_row_end      = r_row_end;
    assign o_frame_end    = r_frame_end;

endmodule

// File: rtl/yuv420_to_bgr_converter.sv
// YUV 4:2:0 to BGR converter, BT.601 limited range.
// Input channel (i_valid/o_ready): one beat is a horizontal luma pair with its
// Cb/Cr pair, in raster order. Chroma is taken on even rows and kept in a line
// store; on odd rows the chroma inputs are ignored and the stored pair of the
// same column is used.
// Output channel (o_valid/i_ready): one beat per input beat, two clamped BGR
// pixels plus row_end and frame_end marks.
// Config channel (i_cfg_valid/o_cfg_ready, always ready): index 0 sets
// pairs_per_row, index 1 sets rows_per_frame; write only while idle.
// Each accepted beat is registered in y2b_line_ctrl, then in the result register.
// Throughput: one beat per cycle while i_ready is high, set by the single port
// of the line store (one write on even rows or one read on odd rows per beat).
// Reset: counters go to the frame origin, both registers to 1, pipeline empty.
// The line store is not cleared; each even row fills it before the odd row.
// Stall: while i_ready is low the result register holds, the stage before it
// fills, and o_ready drops only when both are occupied.
module yuv420_to_bgr_converter #(
    parameter int MAX_PAIRS = 1024,
    parameter int MAX_ROWS  = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [y2b_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [y2b_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [7:0]                      i_luma_first,
    input  logic [7:0]                      i_luma_second,
    input  logic [7:0]                      i_chroma_blue,
    input  logic [7:0]                      i_chroma_red,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [7:0]                      o_blue_first,
    output logic [7:0]                      o_green_first,
    output logic [7:0]                      o_red_first,
    output logic [7:0]                      o_blue_second,
    output logic [7:0]                      o_green_second,
    output logic [7:0]                      o_red_second,
    output logic                            o_row_end,
    output logic                            o_frame_end
);
    import y2b_pkg::*;

    logic  w_pair_valid;
    logic  w_pair_ready;
    t_pair w_pair;

    assign o_cfg_ready = 1'b1;

    y2b_line_ctrl #(
        .MAX_PAIRS (MAX_PAIRS),
        .MAX_ROWS  (MAX_ROWS)
    ) u_line_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_luma_first  (i_luma_first),
        .i_luma_second (i_luma_second),
        .i_chroma_blue (i_chroma_blue),
        .i_chroma_red  (i_chroma_red),
        .o_pair_valid  (w_pair_valid),
        .i_pair_ready  (w_pair_ready),
        .o_pair        (w_pair)
    );

    y2b_convert u_convert (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pair_valid   (w_pair_valid),
        .o_pair_ready   (w_pair_ready),
        .i_pair         (w_pair),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_blue_first   (o_blue_first),
        .o_green_first  (o_green_first),
        .o_red_first    (o_red_first),
        .o_blue_second  (o_blue_second),
        .o_green_second (o_green_second),
        .o_red_second   (o_red_second),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end)
    );

endmodule

// File: rtl/y2b_checker.sv
module y2b_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_ready,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_blue_first,
    input logic [7:0] o_green_first,
    input logic [7:0] o_red_first,
    input logic [7:0] o_blue_second,
    input logic [7:0] o_green_second,
    input logic [7:0] o_red_second,
    input logic       o_row_end,
    input logic       o_frame_end
);

    // the last pair of a frame is always the last pair of a row
    a_frame_implies_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_row_end || !o_frame_end)
        else $error("frame_end without row_end");

    // an empty result register must never hold off the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled while output register empty");

    // nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        $past(i_rst_n) == 1'b0 |-> !o_valid)
        else $error("result beat right after reset");

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_blue_first) && $stable(o_green_first)
            && $stable(o_red_first) && $stable(o_blue_second) && $stable(o_green_second)
            && $stable(o_red_second) && $stable(o_row_end) && $stable(o_frame_end))
        else $error("stalled result beat changed");

endmodule

bind yuv420_to_bgr_converter y2b_checker u_checker (.*);

// File: sim/y2b_bgr_check.sv
`timescale 1ns / 100ps

module y2b_bgr_check #(
    parameter int MAX_PAIRS = 1024,
    parameter int MAX_ROWS  = 2048
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic                            o_cfg_ready,
    input  logic [y2b_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [y2b_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    input  logic                            o_ready,
    input  logic [7:0]                      i_luma_first,
    input  logic [7:0]                      i_luma_second,
    input  logic [7:0]                      i_chroma_blue,
    input  logic [7:0]                      i_chroma_red,
    input  logic                            o_valid,
    input  logic                            i_ready,
    input  logic [7:0]                      o_blue_first,
    input  logic [7:0]                      o_green_first,
    input  logic [7:0]                      o_red_first,
    input  logic [7:0]                      o_blue_second,
    input  logic [7:0]                      o_green_second,
    input  logic [7:0]                      o_red_second,
    input  logic                            o_row_end,
    input  logic                            o_frame_end,
    output int                              o_mismatches,
    output int                              o_outstanding
);
    import y2b_pkg::*;

    localparam int COL_W = $clog2(MAX_PAIRS);
    localparam int ROW_W = $clog2(MAX_ROWS);

    typedef struct packed {
        t_bgr first;
        t_bgr second;
        logic row_end;
        logic frame_end;
    } t_bgr_pair;

    logic [PPR_W-1:0] pairs_reg;
    logic [RPF_W-1:0] rows_reg;
    logic [COL_W-1:0] column;
    logic [ROW_W-1:0] row;
    logic [15:0]      chroma_line [MAX_PAIRS];   // {Cr, Cb}
    t_bgr_pair        expected_pairs [$];
    int               mismatches;

    function automatic logic [7:0] sat8(input int v);
        if (v < 0) return 8'd0;
        if (v > 255) return 8'd255;
        return v[7:0];
    endfunction

    // one rounded, floor-shifted term
    function automatic int scaled(input int k, input int x);
        return (k * x + 128) >>> 8;
    endfunction

    function automatic t_bgr yuv_to_bgr(input logic [7:0] y, input logic [7:0] cb,
                                        input logic [7:0] cr);
        int   c;
        int   d;
        int   e;
        t_bgr px;
        d = int'(cb) - 128;
        e = int'(cr) - 128;
        c = scaled(298, int'(y) - 16);
        px.blue  = sat8(c + scaled(516, d));
        px.green = sat8(c + scaled(-100, d) + scaled(-208, e));
        px.red   = sat8(c + scaled(409, e));
        return px;
    endfunction

    // zero counts as one, anything past the given maximum counts as that maximum
    function automatic int bounded(input int v, input int hi);
        if (v == 0) return 1;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_bgr_pair  want;
        logic [7:0] cb;
        logic [7:0] cr;
        logic       row_last;
        logic       frame_last;
        int         pairs;
        int         rows;
        if (!i_rst_n) begin
            pairs_reg = PPR_W'(1);
            rows_reg  = RPF_W'(1);
            column    = '0;
            row       = '0;
            expected_pairs.delete();
        end else begin
            // result beat first: it can never belong to an input beat of this edge
            if (o_valid && i_ready) begin
                if (expected_pairs.size() == 0) begin
                    $error("result beat with nothing expected");
                    mismatches++;
                end else begin
                    want = expected_pairs.pop_front();
                    check_field("blue_first",   want.first.blue,   o_blue_first);
                    check_field("green_first",  want.first.green,  o_green_first);
                    check_field("red_first",    want.first.red,    o_red_first);
                    check_field("blue_second",  want.second.blue,  o_blue_second);
                    check_field("green_second", want.second.green, o_green_second);
                    check_field("red_second",   want.second.red,   o_red_second);
                    check_field("row_end",      want.row_end,      o_row_end);
                    check_field("frame_end",    want.frame_end,    o_frame_end);
                end
            end

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PAIRS_PER_ROW: begin
                        pairs_reg = i_cfg_data[PPR_W-1:0];
                    end
                    REG_ROWS_PER_FRAME: begin
                        rows_reg = i_cfg_data[RPF_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (i_valid && o_ready) begin
                pairs = bounded(pairs_reg, MAX_PAIRS);
                rows  = bounded(rows_reg, MAX_ROWS);
                if (!row[0]) begin
                    cb = i_chroma_blue;
                    cr = i_chroma_red;
                    chroma_line[column] = {cr, cb};
                end else begin
                    {cr, cb} = chroma_line[column];
                end
                // counters past a shrunk limit end the row / frame right here
                row_last   = int'(column) >= pairs - 1;
                frame_last = row_last && int'(row) >= rows - 1;
                want.first     = yuv_to_bgr(i_luma_first, cb, cr);
                want.second    = yuv_to_bgr(i_luma_second, cb, cr);
                want.row_end   = row_last;
                want.frame_end = frame_last;
                expected_pairs.push_back(want);
                if (row_last) begin
                    column = '0;
                    row    = frame_last ? '0 : row + 1'b1;
                end else begin
                    column = column + 1'b1;
                end
            end
        end
        o_outstanding <= expected_pairs.size();
        o_mismatches  <= mismatches;
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import y2b_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_PAIRS  = 155;

    // index that maps to no register; writes to it must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE     = CFG_INDEX_W'(15);
    localparam logic [CFG_DATA_W-1:0]  DATA_ALL_ONES = '1;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [7:0]             i_luma_first;
    logic [7:0]             i_luma_second;
    logic [7:0]             i_chroma_blue;
    logic [7:0]             i_chroma_red;
    logic                   o_valid;
    logic                   i_ready;
    logic [7:0]             o_blue_first;
    logic [7:0]             o_green_first;
    logic [7:0]             o_red_first;
    logic [7:0]             o_blue_second;
    logic [7:0]             o_green_second;
    logic [7:0]             o_red_second;
    logic                   o_row_end;
    logic                   o_frame_end;

    int   mismatches;
    int   outstanding;
    int   tx_idle_pct;
    int   rx_stall_pct;
    logic pressure_armed;
    logic pressure_done;
    int   cycle_count = 0;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    yuv420_to_bgr_converter uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_blue_first   (o_blue_first),
        .o_green_first  (o_green_first),
        .o_red_first    (o_red_first),
        .o_blue_second  (o_blue_second),
        .o_green_second (o_green_second),
        .o_red_second   (o_red_second),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end)
    );

    y2b_bgr_check bgr_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_luma_first   (i_luma_first),
        .i_luma_second  (i_luma_second),
        .i_chroma_blue  (i_chroma_blue),
        .i_chroma_red   (i_chroma_red),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_blue_first   (o_blue_first),
        .o_green_first  (o_green_first),
        .o_red_first    (o_red_first),
        .o_blue_second  (o_blue_second),
        .o_green_second (o_green_second),
        .o_red_second   (o_red_second),
        .o_row_end      (o_row_end),
        .o_frame_end    (o_frame_end),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    function automatic logic [7:0] pick_sample();
        logic [7:0] corner [6] = '{8'd0, 8'd16, 8'd128, 8'd235, 8'd240, 8'd255};
        if ($urandom_range(0, 99) < 15) return corner[$urandom_range(0, 5)];
        return 8'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // valid stays up across back-to-back beats; it only drops for a gap
    task automatic send_pair(input logic [7:0] y0, input logic [7:0] y1,
                             input logic [7:0] cb, input logic [7:0] cr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_luma_first  <= y0;
        i_luma_second <= y1;
        i_chroma_blue <= cb;
        i_chroma_red  <= cr;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic send_random_pair();
        send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample());
    endtask

    // every beat yields a result, so an empty expectation queue means idle
    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    // receiver: random stalls, plus one long hold-off to back the block up
    initial begin
        i_ready       = 1'b0;
        pressure_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (pressure_armed && !pressure_done) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                pressure_done = 1'b1;
            end
            i_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        int pairs;
        int rows;
        int beats;
        int phase_count;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        i_valid        = 1'b0;
        i_luma_first   = '0;
        i_luma_second  = '0;
        i_chroma_blue  = '0;
        i_chroma_red   = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        pressure_armed = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero registers act as one: every beat closes row and frame
        write_reg(REG_PAIRS_PER_ROW, '0);
        write_reg(REG_ROWS_PER_FRAME, '0);
        send_pair(8'd0,   8'd255, 8'd0,   8'd0);
        send_pair(8'd255, 8'd0,   8'd255, 8'd255);
        send_pair(8'd16,  8'd235, 8'd128, 8'd128);
        send_pair(8'd235, 8'd16,  8'd0,   8'd255);
        send_pair(8'd255, 8'd255, 8'd255, 8'd0);
        send_pair(8'd128, 8'd0,   8'd16,  8'd240);
        settle();

        // 4x4 frame, cut short: shrink the row on an odd row, then the frame
        write_reg(REG_PAIRS_PER_ROW, CFG_DATA_W'(4));
        write_reg(REG_ROWS_PER_FRAME, CFG_DATA_W'(4));
        write_reg(REG_SPARE, CFG_DATA_W'(1));
        repeat (6) send_random_pair();
        settle();
        write_reg(REG_PAIRS_PER_ROW, CFG_DATA_W'(2));
        send_random_pair();
        settle();
        write_reg(REG_ROWS_PER_FRAME, CFG_DATA_W'(2));
        repeat (2) send_random_pair();
        settle();

        // oversized row width clamps to the store size
        write_reg(REG_PAIRS_PER_ROW, DATA_ALL_ONES);
        write_reg(REG_ROWS_PER_FRAME, CFG_DATA_W'(1));
        repeat (3) send_random_pair();
        settle();
        write_reg(REG_PAIRS_PER_ROW, CFG_DATA_W'(2));
        send_random_pair();
        settle();

        // oversized frame height, single-pair rows
        write_reg(REG_PAIRS_PER_ROW, CFG_DATA_W'(1));
        write_reg(REG_ROWS_PER_FRAME, DATA_ALL_ONES);
        repeat (3) send_random_pair();
        settle();
        write_reg(REG_ROWS_PER_FRAME, CFG_DATA_W'(1));
        send_random_pair();
        settle();

        // random whole frames; config changes only at frame boundaries
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 61;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 61;
                end
                default: begin
                    tx_idle_pct  = 23;
                    rx_stall_pct = 23;
                end
            endcase
            phase_count = 0;
            while (phase_count < PHASE_PAIRS) begin
                if ($urandom_range(0, 9) < 8) pairs = $urandom_range(0, 6);
                else pairs = $urandom_range(7, 24);
                rows = $urandom_range(0, 8);
                if (phase == 0 && phase_count == 0) begin
                    pairs = 16;
                    rows  = 4;
                end
                write_reg(REG_PAIRS_PER_ROW, CFG_DATA_W'(pairs));
                write_reg(REG_ROWS_PER_FRAME, CFG_DATA_W'(rows));
                if (phase == 0 && phase_count == 0) pressure_armed <= 1'b1;
                beats = $urandom_range(1, 2) * (pairs == 0 ? 1 : pairs) *
                        (rows == 0 ? 1 : rows);
                repeat (beats) send_random_pair();
                phase_count += beats;
                settle();
            end
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
